// ===== hdl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, constants and helper functions for the byte pattern search
// unit.
// ----------------------------------------------------------------------------
package bps_pkg;

    // Pattern geometry
    localparam int PAT_MAX    = 16;
    localparam int PAT_BYTES  = 16;                      // bytes held by the two pattern regs
    localparam int PAT_IDX_W  = $clog2(PAT_BYTES);
    localparam int PAT_LEN_W  = 5;                       // width of the length register
    localparam int WIN_IDX_W  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;

    // Haystack geometry
    localparam int POS_W      = 16;
    localparam logic [POS_W-1:0] HAY_MAX = 16'd65535;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int START_W    = 18;
    localparam int HLEN_W     = 16;
    localparam int OFFS_W     = 17;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAT_LOW  = 3'd0,
        REG_PAT_HIGH = 3'd1,
        REG_PAT_LEN  = 3'd2,
        REG_MODE     = 3'd3,
        REG_START    = 3'd4,
        REG_HAY_LEN  = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        MODE_FIRST = 1'b0,
        MODE_LAST  = 1'b1
    } search_mode_t;

    // Configuration register bundle
    typedef struct packed {
        logic [63:0]          pattern_low_bytes;
        logic [63:0]          pattern_high_bytes;
        logic [PAT_LEN_W-1:0] pattern_length;
        search_mode_t         search_mode;
        logic [START_W-1:0]   start_offset;
        logic [HLEN_W-1:0]    haystack_length;
    } cfg_t;

    // One haystack transaction held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] hay_byte;
        logic              final_byte;
    } item_t;

    // Pattern length in use: zero acts as one, large values saturate
    function automatic logic [PAT_LEN_W-1:0] eff_length(input logic [PAT_LEN_W-1:0] len);
        logic [PAT_LEN_W-1:0] n;
        n = len;
        if (n == '0) begin
            n = PAT_LEN_W'(1);
        end
        if (n > PAT_LEN_W'(PAT_MAX)) begin
            n = PAT_LEN_W'(PAT_MAX);
        end
        return n;
    endfunction

    // Resolve the signed start offset against the haystack length
    function automatic logic [POS_W-1:0] norm_start(input logic [START_W-1:0] raw,
                                                    input logic [HLEN_W-1:0]  len);
        logic [START_W-1:0] mag;
        logic [START_W-1:0] len_x;
        logic [POS_W-1:0]   res;
        len_x = {{(START_W-HLEN_W){1'b0}}, len};
        mag   = START_W'(0) - raw;
        if (raw[START_W-1]) begin
            res = (mag >= len_x) ? '0 : POS_W'(len - mag[HLEN_W-1:0]);
        end else begin
            res = (raw > len_x) ? POS_W'(len) : raw[POS_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/bps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bps_cfg_regs
// Configuration register file; decodes writes on the configuration channel.
// ----------------------------------------------------------------------------
module bps_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bps_pkg::cfg_t                   cfg
);

    bps_pkg::cfg_t cfg_reg;
    bps_pkg::cfg_t cfg_next;

    // Always able to take a write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bps_pkg::REG_PAT_LOW:  cfg_next.pattern_low_bytes  = cfg_data;
                bps_pkg::REG_PAT_HIGH: cfg_next.pattern_high_bytes = cfg_data;
                bps_pkg::REG_PAT_LEN:
                    cfg_next.pattern_length = cfg_data[bps_pkg::PAT_LEN_W-1:0];
                bps_pkg::REG_MODE:
                    cfg_next.search_mode = bps_pkg::search_mode_t'(cfg_data[0]);
                bps_pkg::REG_START:
                    cfg_next.start_offset = cfg_data[bps_pkg::START_W-1:0];
                bps_pkg::REG_HAY_LEN:
                    cfg_next.haystack_length = cfg_data[bps_pkg::HLEN_W-1:0];
                default: ;   // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low_bytes  <= '0;
            cfg_reg.pattern_high_bytes <= '0;
            cfg_reg.pattern_length     <= bps_pkg::PAT_LEN_W'(1);
            cfg_reg.search_mode        <= bps_pkg::MODE_FIRST;
            cfg_reg.start_offset       <= '0;
            cfg_reg.haystack_length    <= bps_pkg::HLEN_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/bps_in_reg.sv =====
// ----------------------------------------------------------------------------
// bps_in_reg
// Input register for haystack bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module bps_in_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bps_pkg::BYTE_W-1:0]   s_tdata,    // [7:0] hay_byte
    input  logic                         s_tlast,    // final_byte
    input  logic                         take,
    output bps_pkg::item_t               item
);

    bps_pkg::item_t item_reg;

    assign s_tready = !item_reg.valid || take;
    assign item     = item_reg;

    // Load on accept, empty when the core takes the byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.valid <= 1'b0;
        end else if (s_tready) begin
            item_reg.valid <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            item_reg.hay_byte   <= s_tdata;
            item_reg.final_byte <= s_tlast;
        end
    end

endmodule

// ===== hdl/bps_match_core.sv =====
// ----------------------------------------------------------------------------
// bps_match_core
// Byte window, parallel pattern compare, match tracking and result register.
// ----------------------------------------------------------------------------
module bps_match_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bps_pkg::item_t                    item,
    output logic                              take,
    input  bps_pkg::cfg_t                     cfg,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,   // [16:0] match_offset, rest zero
    output logic                              m_tuser    // found
);

    logic [bps_pkg::BYTE_W-1:0]    win_reg  [bps_pkg::PAT_MAX];
    logic [bps_pkg::BYTE_W-1:0]    win_next [bps_pkg::PAT_MAX];
    logic [bps_pkg::BYTE_W-1:0]    pat_bytes[bps_pkg::PAT_BYTES];
    logic [bps_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          seen_reg, seen_next;
    logic [bps_pkg::POS_W-1:0]     best_reg, best_next;
    logic                          seen_scan;
    logic [bps_pkg::POS_W-1:0]     best_scan;
    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [bps_pkg::OFFS_W-1:0]    out_offs_reg;
    logic [bps_pkg::PAT_LEN_W-1:0] n_eff;
    logic [bps_pkg::POS_W-1:0]     start_pos;
    logic [bps_pkg::POS_W-1:0]     match_start;
    logic                          active;
    logic                          hit;

    // Process the held byte unless it is final and the result slot is busy
    assign take = item.valid &&
                  (!item.final_byte || !out_valid_reg || m_tready);
    assign active = take && (pos_reg < bps_pkg::HAY_MAX);

    assign n_eff     = bps_pkg::eff_length(cfg.pattern_length);
    assign start_pos = bps_pkg::norm_start(cfg.start_offset, cfg.haystack_length);

    // Pattern bytes as an array, byte 0 lowest
    always_comb begin
        for (int k = 0; k < bps_pkg::PAT_BYTES; k++) begin
            if (k < 8) begin
                pat_bytes[k] = cfg.pattern_low_bytes[8*k +: 8];
            end else begin
                pat_bytes[k] = cfg.pattern_high_bytes[8*(k-8) +: 8];
            end
        end
    end

    // Window after shifting in the new byte, newest at index 0
    always_comb begin
        win_next[0] = item.hay_byte;
        for (int i = 1; i < bps_pkg::PAT_MAX; i++) begin
            win_next[i] = win_reg[i-1];
        end
    end

    // Parallel compare: window slot j holds pattern byte n-1-j
    always_comb begin
        logic [bps_pkg::PAT_LEN_W-1:0] idx;
        hit = 1'b1;
        for (int j = 0; j < bps_pkg::PAT_MAX; j++) begin
            idx = n_eff - bps_pkg::PAT_LEN_W'(1) - bps_pkg::PAT_LEN_W'(j);
            if ((bps_pkg::PAT_LEN_W'(j) < n_eff) &&
                (win_next[j] != pat_bytes[idx[bps_pkg::PAT_IDX_W-1:0]])) begin
                hit = 1'b0;
            end
        end
    end

    // Stream state update; the scan values include the current byte
    always_comb begin
        pos_next    = pos_reg;
        seen_scan   = seen_reg;
        best_scan   = best_reg;
        match_start = pos_reg + bps_pkg::POS_W'(1) - bps_pkg::POS_W'(n_eff);
        if (active) begin
            pos_next = pos_reg + bps_pkg::POS_W'(1);
            if ((pos_next >= bps_pkg::POS_W'(n_eff)) && hit &&
                (match_start >= start_pos)) begin
                if ((cfg.search_mode == bps_pkg::MODE_LAST) || !seen_reg) begin
                    best_scan = match_start;
                end
                seen_scan = 1'b1;
            end
        end
        seen_next = seen_scan;
        best_next = best_scan;
        // Final byte closes the haystack
        if (take && item.final_byte) begin
            pos_next  = '0;
            seen_next = 1'b0;
            best_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            seen_reg <= 1'b0;
            best_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            seen_reg <= seen_next;
            best_reg <= best_next;
        end
    end

    // Window only shifts on bytes that are scanned (taken, below the position limit)
    always_ff @(posedge aclk) begin
        if (active) begin
            for (int i = 0; i < bps_pkg::PAT_MAX; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && item.final_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && item.final_byte) begin
            out_found_reg <= seen_scan;
            out_offs_reg  <= seen_scan ? {1'b0, best_scan} : '1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{(24-bps_pkg::OFFS_W){1'b0}}, out_offs_reg};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= bps_pkg::HAY_MAX)
        else $error("byte position beyond haystack limit");

    a_best_before_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (best_reg < pos_reg))
        else $error("recorded match starts past streamed bytes");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.final_byte) |=> (pos_reg == '0) && !seen_reg)
        else $error("stream state not cleared after final byte");

    a_final_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && item.final_byte) |=> out_valid_reg)
        else $error("final byte produced no result");

    a_offs_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_found_reg ? !out_offs_reg[bps_pkg::OFFS_W-1]
                                         : (out_offs_reg == '1)))
        else $error("result offset disagrees with found flag");

endmodule

// ===== hdl/byte_pattern_search_unit.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_search_unit
// Streaming search for a 1 to 16 byte pattern in a haystack byte stream.
// ----------------------------------------------------------------------------
// Haystack bytes enter on the s_ stream, one per transaction, with s_tlast on
// the last byte. The unit takes one byte per clock: a byte is compared in
// parallel against the whole window while it sits in the input register, and
// the result register loads when the final byte is taken, so m_tvalid rises
// once the last byte has left the input register. Only the final byte waits,
// and only while the result register still holds an untaken result. Each
// haystack yields exactly one result transaction: m_tuser is the found flag,
// m_tdata[16:0] the signed start index of the first (or, in last mode, the
// latest) overlapping match at or after the normalized start offset, or -1
// when there is none. Bytes past the 65535th are not matched. Write
// configuration between transactions of a haystack or between haystacks; a
// write applies from the next byte.
// ----------------------------------------------------------------------------
module byte_pattern_search_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // haystack stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] hay_byte
    input  logic                            s_tlast,    // final_byte
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,    // [16:0] match_offset, [23:17] zero
    output logic                            m_tuser,    // found
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bps_pkg::cfg_t  cfg;
    bps_pkg::item_t item;
    logic           take;

    bps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bps_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .item     (item)
    );

    bps_match_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .take     (take),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte pattern search unit.
// ----------------------------------------------------------------------------
// Haystack bytes are queued by the stimulus process and offered on the s_
// stream by a falling-edge driver. A rising-edge monitor runs every accepted
// byte through a bench-side scanner, which queues the result due at each
// final byte. Result transactions are compared field by field, in order.
// Registers are rewritten between phases only, once the unit has drained.
// Phases cover directed corner cases, random haystacks under four idle
// patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] hay_byte;
        logic              final_byte;
    } hay_item_t;

    typedef struct packed {
        logic              found;
        logic [OFFS_W-1:0] offset;
    } search_result_t;

    // DUT signals
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    byte_pattern_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench bookkeeping
    hay_item_t      hay_pending[$];
    search_result_t results_due[$];
    search_result_t mon_want;
    hay_item_t      tx_next;
    int             errors       = 0;
    logic           in_taken     = 1'b0;
    int             tx_idle_pct  = 0;
    int             rx_stall_pct = 0;
    int             hold_req     = 0;
    int             hold_seen    = 0;
    int             hold_left    = 0;

    // Scanner copy of the registers
    logic [127:0]       pat_bytes;
    logic [PAT_LEN_W-1:0] pat_len_reg;
    search_mode_t       mode_reg;
    logic [START_W-1:0] start_reg;
    logic [HLEN_W-1:0]  hay_len_reg;

    // Scanner copy of the stream state
    logic [7:0]         win [PAT_MAX];
    logic [16:0]        hay_pos;
    logic               hit_seen;
    logic [15:0]        hit_offset;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pattern bytes in use for a given length register value
    function automatic int pattern_span(logic [PAT_LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > PAT_MAX) return PAT_MAX;
        return int'(len);
    endfunction

    // Lowest start index a match may have
    function automatic logic [16:0] search_floor();
        logic [17:0] mag;
        mag = 18'd0 - start_reg;
        if (start_reg[17]) begin
            if (mag >= {2'b00, hay_len_reg}) return 17'd0;
            return {1'b0, hay_len_reg - mag[15:0]};
        end
        if (start_reg > {2'b00, hay_len_reg}) return {1'b0, hay_len_reg};
        return start_reg[16:0];
    endfunction

    function automatic void clear_scan();
        for (int i = 0; i < PAT_MAX; i++) win[i] = 8'h00;
        hay_pos    = '0;
        hit_seen   = 1'b0;
        hit_offset = '0;
    endfunction

    // Advance the scanner by one accepted byte; queue a result on the final one
    function automatic void scan_hay_byte(logic [7:0] b, logic last);
        int          n;
        logic        hit;
        logic [16:0] s;
        if (hay_pos < 17'(HAY_MAX)) begin
            n = pattern_span(pat_len_reg);
            for (int i = PAT_MAX - 1; i > 0; i--) win[i] = win[i-1];
            win[0]  = b;
            hay_pos = hay_pos + 17'd1;
            if (hay_pos >= n) begin
                s   = hay_pos - 17'(n);
                hit = 1'b1;
                for (int k = 0; k < n; k++) begin
                    if (win[n-1-k] != pat_bytes[8*k +: 8]) hit = 1'b0;
                end
                if (hit && s >= search_floor()) begin
                    if (mode_reg == MODE_LAST || !hit_seen) hit_offset = s[15:0];
                    hit_seen = 1'b1;
                end
            end
        end
        if (last) begin
            results_due.push_back('{hit_seen, hit_seen ? {1'b0, hit_offset} : 17'h1FFFF});
            clear_scan();
        end
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last);
        hay_pending.push_back('{b, last});
    endfunction

    function automatic void push_run(logic [7:0] b, int count);
        for (int i = 0; i < count; i++) push_byte(b, i == count - 1);
    endfunction

    // One random haystack: pattern copies, broken prefixes, pattern bytes, noise
    function automatic int make_haystack(int target);
        logic [7:0] bytes[$];
        int         n;
        int         r;
        int         cut;
        int         pick;
        n = pattern_span(pat_len_reg);
        while (bytes.size() < target) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                for (int k = 0; k < n; k++) bytes.push_back(pat_bytes[8*k +: 8]);
            end else if (r < 5) begin
                cut = $urandom_range(1, n);
                for (int k = 0; k < cut; k++) bytes.push_back(pat_bytes[8*k +: 8]);
            end else if (r < 8) begin
                pick = $urandom_range(0, n - 1);
                bytes.push_back(pat_bytes[8*pick +: 8]);
            end else begin
                bytes.push_back(8'($urandom));
            end
        end
        foreach (bytes[i]) push_byte(bytes[i], i == bytes.size() - 1);
        return bytes.size();
    endfunction

    // Register write transaction; the scanner copy follows on acceptance
    task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_PAT_LOW:  pat_bytes[63:0]   = val;
            REG_PAT_HIGH: pat_bytes[127:64] = val;
            REG_PAT_LEN:  pat_len_reg       = val[PAT_LEN_W-1:0];
            REG_MODE:     mode_reg          = search_mode_t'(val[0]);
            REG_START:    start_reg         = val[START_W-1:0];
            REG_HAY_LEN:  hay_len_reg       = val[HLEN_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every byte is taken and every result has come, then drain
    task automatic settle();
        while (hay_pending.size() != 0 || s_tvalid || results_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Full register set for one random phase, with fixed extremes early on
    task automatic pick_config(int ph);
        logic [PAT_LEN_W-1:0] len;
        logic [START_W-1:0]   st;
        logic [HLEN_W-1:0]    hl;
        search_mode_t         md;
        case ($urandom_range(0, 9))
            0:       len = '0;
            1:       len = PAT_LEN_W'(PAT_MAX);
            2:       len = PAT_LEN_W'($urandom_range(17, 31));
            default: len = PAT_LEN_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 9))
            0:       hl = '0;
            1:       hl = 16'hFFFF;
            2:       hl = 16'd1;
            default: hl = 16'($urandom_range(2, 40));
        endcase
        case ($urandom_range(0, 9))
            0:       st = 18'h20000;                // -131072
            1:       st = 18'h10000;                // +65536
            2:       st = 18'($urandom);
            3:       st = '0;
            default: st = 18'($urandom_range(0, 80)) - 18'd40;
        endcase
        md = search_mode_t'($urandom_range(0, 1));
        case (ph)
            0: begin len = PAT_LEN_W'(PAT_MAX); st = 18'h20000; hl = 16'hFFFF; md = MODE_FIRST; end
            1: begin st = 18'h10000; hl = '0; md = MODE_LAST; end
            2: begin len = 5'd31; st = 18'h3FFFF; hl = 16'd1; end
            default: ;
        endcase
        write_reg(REG_PAT_LOW,  {$urandom, $urandom});
        write_reg(REG_PAT_HIGH, {$urandom, $urandom});
        write_reg(REG_PAT_LEN,  64'(len));
        write_reg(REG_MODE,     64'(md));
        write_reg(REG_START,    64'(st));
        write_reg(REG_HAY_LEN,  64'(hl));
    endtask

    // Input driver: new transaction after acceptance, random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (hay_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                tx_next = hay_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= tx_next.hay_byte;
                s_tlast  <= tx_next.final_byte;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= 300;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Monitor: feed accepted bytes to the scanner, check result transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) scan_hay_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual found=%0b offset=%0d",
                             $time, m_tuser, $signed(m_tdata[16:0]));
                end else begin
                    mon_want = results_due.pop_front();
                    if (m_tuser !== mon_want.found) begin
                        errors++;
                        $display("%0t: found mismatch, expected %0b, actual %0b",
                                 $time, mon_want.found, m_tuser);
                    end
                    if (m_tdata[16:0] !== mon_want.offset) begin
                        errors++;
                        $display("%0t: match_offset mismatch, expected %0d, actual %0d",
                                 $time, $signed(mon_want.offset), $signed(m_tdata[16:0]));
                    end
                    if (m_tdata[23:17] !== 7'd0) begin
                        errors++;
                        $display("%0t: tdata pad mismatch, expected 0, actual %h",
                                 $time, m_tdata[23:17]);
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        int budget;
        int target;
        pat_bytes   = '0;
        pat_len_reg = PAT_LEN_W'(1);
        mode_reg    = MODE_FIRST;
        start_reg   = '0;
        hay_len_reg = HLEN_W'(1);
        clear_scan();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset registers: single zero byte pattern, hit and miss
        push_run(8'h00, 1);
        push_run(8'hFF, 1);
        settle();

        // Overlapping two-byte pattern, first then last mode
        write_reg(REG_PAT_LOW, 64'h4141);
        write_reg(REG_PAT_LEN, 64'd2);
        write_reg(REG_HAY_LEN, 64'd4);
        push_run(8'h41, 3);
        settle();
        write_reg(REG_MODE, 64'(MODE_LAST));
        push_run(8'h41, 3);
        settle();

        // Negative start counts back from the length; zero length gives zero
        write_reg(REG_MODE, 64'(MODE_FIRST));
        write_reg(REG_START, 64'(18'h3FFFE));
        push_run(8'h41, 4);
        settle();
        write_reg(REG_HAY_LEN, 64'd0);
        push_run(8'h41, 3);
        settle();

        // Start past the length clamps to the length
        write_reg(REG_START, 64'd100);
        write_reg(REG_HAY_LEN, 64'd4);
        push_run(8'h41, 4);
        settle();

        // Length zero acts as one
        write_reg(REG_START, 64'd0);
        write_reg(REG_PAT_LEN, 64'd0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h41, 1'b1);
        settle();

        // Length above the maximum saturates to a full 16 byte pattern
        write_reg(REG_PAT_LOW,  {$urandom, $urandom});
        write_reg(REG_PAT_HIGH, {$urandom, $urandom});
        write_reg(REG_PAT_LEN, 64'd31);
        for (int k = 0; k < PAT_MAX; k++) push_byte(pat_bytes[8*k +: 8], k == PAT_MAX - 1);
        settle();

        // Random phases, cycling through the idle patterns
        for (int ph = 0; ph < 8; ph++) begin
            pick_config(ph);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            budget = 0;
            while (budget < 240) begin
                if (hay_len_reg > 0 && hay_len_reg < 48)
                    target = $urandom_range(1, int'(hay_len_reg) + 4);
                else
                    target = $urandom_range(1, 30);
                budget += make_haystack(target);
            end
            settle();
        end

        // Long receiver hold-off while short haystacks keep coming
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        pick_config(8);
        hold_req++;
        for (int h = 0; h < 40; h++) void'(make_haystack($urandom_range(1, 3)));
        settle();

        repeat (20) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
